### rtl/core/amts_pkg.sv
// Shared types and codes for the adjacency matrix topological sort unit.
// Used by the channel interfaces, the controller and the datapath.
`default_nettype none
package amts_pkg;

  localparam int OP_W     = 3;
  localparam int SLOT_W   = 5;
  localparam int STATUS_W = 3;

  localparam logic [OP_W-1:0] OP_ADD_NODE = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL_NODE = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_EDGE = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_EDGE = 3'd3;
  localparam logic [OP_W-1:0] OP_SORT     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DONE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NONODE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CYCLIC = 3'd4;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_EDIT,
    EMIT_NODE,
    EMIT_CYCLIC,
    EMIT_DONE
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  sort_init;
    logic  round_init;
    logic  idx_inc;
    logic  round_close;
    emit_t emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] in_op;
    logic            out_free;
    logic            self_loop;
    logic            cand;
    logic            idx_last;
    logic            all_visited;
    logic            found_none;
  } dp_status_t;

endpackage
`default_nettype wire

### rtl/core/amts_cmd_if.sv
// Command channel: valid, ready and the request payload (op, src, dest).
// Depends on amts_pkg for field widths.
`default_nettype none
interface amts_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [amts_pkg::OP_W-1:0]   op;
  logic [amts_pkg::SLOT_W-1:0] src;
  logic [amts_pkg::SLOT_W-1:0] dest;

  modport source (output valid, output op, output src, output dest, input ready);
  modport sink (input valid, input op, input src, input dest, output ready);
endinterface
`default_nettype wire

### rtl/core/amts_result_if.sv
// Result channel: valid, ready and the result payload (status, node, last).
// Depends on amts_pkg for field widths.
`default_nettype none
interface amts_result_if;
  logic                          valid;
  logic                          ready;
  logic [amts_pkg::STATUS_W-1:0] status;
  logic [amts_pkg::SLOT_W-1:0]   node;
  logic                          last;

  modport source (output valid, output status, output node, output last, input ready);
  modport sink (input valid, input status, input node, input last, output ready);
endinterface
`default_nettype wire

### rtl/core/amts_ctrl.sv
// Controller state machine: accepts requests and sequences edits and sort rounds.
// Depends on amts_pkg for the command and status structs.
`default_nettype none
module amts_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire amts_pkg::dp_status_t stat,
  output amts_pkg::dp_cmd_t         ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SELF   = 3'd2;
  localparam logic [2:0] S_RSTART = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_REND   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd_ready       = 1'b0;
    ctl.load        = 1'b0;
    ctl.sort_init   = 1'b0;
    ctl.round_init  = 1'b0;
    ctl.idx_inc     = 1'b0;
    ctl.round_close = 1'b0;
    ctl.emit        = amts_pkg::EMIT_NONE;
    unique case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.load = 1'b1;
          case (stat.in_op) inside
            amts_pkg::OP_ADD_NODE, amts_pkg::OP_DEL_NODE,
            amts_pkg::OP_ADD_EDGE, amts_pkg::OP_DEL_EDGE: begin
              state_next = S_EXEC;
            end
            amts_pkg::OP_SORT: begin
              ctl.sort_init = 1'b1;
              state_next    = S_SELF;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          ctl.emit   = amts_pkg::EMIT_EDIT;
          state_next = S_IDLE;
        end
      end
      S_SELF: begin
        if (stat.self_loop) begin
          if (stat.out_free) begin
            ctl.emit   = amts_pkg::EMIT_CYCLIC;
            state_next = S_IDLE;
          end
        end else if (stat.idx_last) begin
          state_next = S_RSTART;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_RSTART: begin
        if (stat.all_visited) begin
          if (stat.out_free) begin
            ctl.emit   = amts_pkg::EMIT_DONE;
            state_next = S_IDLE;
          end
        end else begin
          ctl.round_init = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.cand || stat.out_free) begin
          if (stat.cand) begin
            ctl.emit = amts_pkg::EMIT_NODE;
          end
          if (stat.idx_last) begin
            state_next = S_REND;
          end else begin
            ctl.idx_inc = 1'b1;
          end
        end
      end
      S_REND: begin
        if (stat.found_none) begin
          if (stat.out_free) begin
            ctl.emit   = amts_pkg::EMIT_CYCLIC;
            state_next = S_IDLE;
          end
        end else begin
          ctl.round_close = 1'b1;
          state_next      = S_RSTART;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/amts_datapath.sv
// Datapath: edge matrix, slot valid bits, sort masks, scan index and result register.
// Depends on amts_pkg and amts_result_if; driven by amts_ctrl.
`default_nettype none
module amts_datapath #(
  parameter int MAX_NODES = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [amts_pkg::OP_W-1:0]     in_op,
  input  wire logic [amts_pkg::SLOT_W-1:0]   in_source,
  input  wire logic [amts_pkg::SLOT_W-1:0]   in_dest,
  input  wire amts_pkg::dp_cmd_t             ctl,
  output amts_pkg::dp_status_t               stat,
  amts_result_if.source                      result
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  logic [MAX_NODES-1:0] rows [MAX_NODES];
  logic [MAX_NODES-1:0] valid_bits;
  logic [CW-1:0]        count;
  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] open;
  logic [MAX_NODES-1:0] found;
  logic [IW-1:0]        idx;

  logic [amts_pkg::OP_W-1:0]   op_q;
  logic [amts_pkg::SLOT_W-1:0] src_q;
  logic [amts_pkg::SLOT_W-1:0] dst_q;

  logic                          out_valid;
  logic [amts_pkg::STATUS_W-1:0] out_status;
  logic [amts_pkg::SLOT_W-1:0]   out_node;
  logic                          out_last;

  logic [IW-1:0]        srci;
  logic [IW-1:0]        dsti;
  logic                 src_ok;
  logic                 dst_ok;
  logic                 full;
  logic [IW-1:0]        free_idx;
  logic [MAX_NODES-1:0] row_sel;

  assign srci   = IW'(src_q);
  assign dsti   = IW'(dst_q);
  assign src_ok = (32'(src_q) < MAX_NODES) && valid_bits[srci];
  assign dst_ok = (32'(dst_q) < MAX_NODES) && valid_bits[dsti];
  assign full   = (count == CW'(MAX_NODES));
  assign row_sel = rows[idx];

  always_comb begin
    free_idx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (!valid_bits[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign stat.in_op       = in_op;
  assign stat.out_free    = !out_valid || result.ready;
  assign stat.self_loop   = valid_bits[idx] && row_sel[idx];
  assign stat.cand        = open[idx] && ((row_sel & open) == '0);
  assign stat.idx_last    = (idx == IW'(MAX_NODES - 1));
  assign stat.all_visited = &visited;
  assign stat.found_none  = (found == '0);

  assign result.valid  = out_valid;
  assign result.status = out_status;
  assign result.node   = out_node;
  assign result.last   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAX_NODES; r++) begin
        rows[r] <= '0;
      end
      valid_bits <= '0;
      count      <= '0;
      visited    <= '0;
      open       <= '0;
      found      <= '0;
      idx        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ctl.emit != amts_pkg::EMIT_NONE) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.load) begin
        op_q  <= in_op;
        src_q <= in_source;
        dst_q <= in_dest;
      end
      if (ctl.sort_init) begin
        visited <= ~valid_bits;
        idx     <= '0;
      end
      if (ctl.round_init) begin
        open  <= ~visited;
        found <= '0;
        idx   <= '0;
      end
      if (ctl.idx_inc) begin
        idx <= idx + IW'(1);
      end
      if (ctl.round_close) begin
        visited <= visited | found;
      end
      case (ctl.emit)
        amts_pkg::EMIT_EDIT: begin
          out_last <= 1'b1;
          case (op_q)
            amts_pkg::OP_ADD_NODE: begin
              if (full) begin
                out_status <= amts_pkg::ST_FULL;
                out_node   <= '0;
              end else begin
                out_status           <= amts_pkg::ST_OK;
                valid_bits[free_idx] <= 1'b1;
                rows[free_idx]       <= '0;
                count                <= count + CW'(1);
                out_node             <= amts_pkg::SLOT_W'(free_idx);
              end
            end
            amts_pkg::OP_DEL_NODE: begin
              out_node <= '0;
              if (!src_ok) begin
                out_status <= amts_pkg::ST_NONODE;
              end else begin
                out_status <= amts_pkg::ST_OK;
                for (int r = 0; r < MAX_NODES; r++) begin
                  if (IW'(r) == srci) begin
                    rows[r] <= '0;
                  end else begin
                    rows[r][srci] <= 1'b0;
                  end
                end
                valid_bits[srci] <= 1'b0;
                count            <= count - CW'(1);
              end
            end
            amts_pkg::OP_ADD_EDGE, amts_pkg::OP_DEL_EDGE: begin
              out_node <= '0;
              if (!src_ok || !dst_ok) begin
                out_status <= amts_pkg::ST_NONODE;
              end else begin
                out_status       <= amts_pkg::ST_OK;
                rows[dsti][srci] <= (op_q == amts_pkg::OP_ADD_EDGE);
              end
            end
            default: begin
              out_status <= amts_pkg::ST_OK;
              out_node   <= '0;
            end
          endcase
        end
        amts_pkg::EMIT_NODE: begin
          out_status <= amts_pkg::ST_OK;
          out_node   <= amts_pkg::SLOT_W'(idx);
          out_last   <= 1'b0;
          found[idx] <= 1'b1;
        end
        amts_pkg::EMIT_CYCLIC: begin
          out_status <= amts_pkg::ST_CYCLIC;
          out_node   <= '0;
          out_last   <= 1'b1;
        end
        amts_pkg::EMIT_DONE: begin
          out_status <= amts_pkg::ST_DONE;
          out_node   <= '0;
          out_last   <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    32'(count) == $countones(valid_bits))
    else $error("Node count disagrees with the slot valid bits.");

  a_found_in_open: assert property (@(posedge clk) disable iff (rst)
    (found & ~open) == '0)
    else $error("A node was emitted that was not open in this round.");

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit != amts_pkg::EMIT_NONE) |-> (!out_valid || result.ready))
    else $error("A result was loaded over one that was not yet taken.");

  a_open_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.emit == amts_pkg::EMIT_NODE |-> valid_bits[idx])
    else $error("The sort emitted an empty slot.");
`endif

endmodule
`default_nettype wire

### rtl/core/adjacency_matrix_topological_sort_unit.sv
// Adjacency matrix topological sort unit: top level joining controller and datapath.
// Depends on amts_pkg, amts_cmd_if, amts_result_if, amts_ctrl and amts_datapath.
//
// Requests arrive on the cmd channel (op, src, dest) and results leave on the
// result channel (status, node, last); a transfer happens when valid and ready are
// both high. One request is worked at a time; cmd.ready is high only while the
// unit waits for a new request, and it may rise while a result still sits in the
// output register. Edits (add or remove a node or an edge) give one result each.
// Opcodes with no meaning give no result and free the unit on the next cycle. A
// sort first checks every slot for a self-loop, one slot per cycle, then runs
// rounds of one scan over all slots, one slot per cycle while the output register
// is free, each round with a setup step before its scan and a close step after;
// it yields up to MAX_NODES + 1 results, the last one marked by last.
// When the receiver stalls, the result is held in the output register and the
// scan waits on it.
// Synchronous reset clears the graph, the masks and the channels at once.
`default_nettype none
module adjacency_matrix_topological_sort_unit #(
  parameter int MAX_NODES = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  amts_cmd_if.sink     cmd,
  amts_result_if.source result
);

  amts_pkg::dp_cmd_t    ctl;
  amts_pkg::dp_status_t stat;

  amts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  amts_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_op     (cmd.op),
    .in_source (cmd.src),
    .in_dest   (cmd.dest),
    .ctl       (ctl),
    .stat      (stat),
    .result    (result)
  );

endmodule
`default_nettype wire

### tb/amts_tb_pkg.sv
// Scoreboard for the adjacency matrix topological sort unit testbench.
// Tracks the graph, predicts the results of each request and checks them.
// Depends on amts_pkg for field widths, opcodes and status codes.
package amts_tb_pkg;
  import amts_pkg::*;

  localparam int GRAPH_SLOTS = 32;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   node;
    logic                last;
  } graph_result_t;

  class toposort_scoreboard;
    bit [GRAPH_SLOTS-1:0] edge_rows [GRAPH_SLOTS];
    bit [GRAPH_SLOTS-1:0] node_valid;
    bit [5:0]             node_count;
    bit [GRAPH_SLOTS-1:0] visited;
    graph_result_t        expected_q[$];
    int                   errors;

    function new();
      foreach (edge_rows[i]) edge_rows[i] = '0;
      node_valid = '0;
      node_count = '0;
      visited    = '0;
      errors     = 0;
    endfunction

    function void queue_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] node,
                               logic last);
      graph_result_t r;
      r.status = status;
      r.node   = node;
      r.last   = last;
      expected_q.push_back(r);
    endfunction

    function bit slot_present(int s);
      return s < GRAPH_SLOTS && node_valid[s];
    endfunction

    function void predict_sort();
      bit [GRAPH_SLOTS-1:0] open;
      bit [GRAPH_SLOTS-1:0] found;
      visited = ~node_valid;
      for (int i = 0; i < GRAPH_SLOTS; i++) begin
        if (node_valid[i] && edge_rows[i][i]) begin
          queue_result(ST_CYCLIC, '0, 1'b1);
          return;
        end
      end
      // Each round emits every open node whose row has no bit among the open nodes.
      while (visited != '1) begin
        open  = ~visited;
        found = '0;
        for (int i = 0; i < GRAPH_SLOTS; i++) begin
          if (open[i] && (edge_rows[i] & open) == '0) begin
            found[i] = 1'b1;
            queue_result(ST_OK, SLOT_W'(i), 1'b0);
          end
        end
        if (found == '0) begin
          queue_result(ST_CYCLIC, '0, 1'b1);
          return;
        end
        visited |= found;
      end
      queue_result(ST_DONE, '0, 1'b1);
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] src,
                               logic [SLOT_W-1:0] dst);
      bit placed;
      placed = 1'b0;
      case (op)
        OP_ADD_NODE: begin
          for (int i = 0; i < GRAPH_SLOTS && !placed; i++) begin
            if (!node_valid[i]) begin
              node_valid[i] = 1'b1;
              edge_rows[i]  = '0;
              node_count++;
              queue_result(ST_OK, SLOT_W'(i), 1'b1);
              placed = 1'b1;
            end
          end
          if (!placed) queue_result(ST_FULL, '0, 1'b1);
        end
        OP_DEL_NODE: begin
          if (!slot_present(src)) begin
            queue_result(ST_NONODE, '0, 1'b1);
          end else begin
            edge_rows[src] = '0;
            foreach (edge_rows[i]) edge_rows[i][src] = 1'b0;
            node_valid[src] = 1'b0;
            node_count--;
            queue_result(ST_OK, '0, 1'b1);
          end
        end
        OP_ADD_EDGE, OP_DEL_EDGE: begin
          if (!slot_present(src) || !slot_present(dst)) begin
            queue_result(ST_NONODE, '0, 1'b1);
          end else begin
            edge_rows[dst][src] = (op == OP_ADD_EDGE);
            queue_result(ST_OK, '0, 1'b1);
          end
        end
        OP_SORT: predict_sort();
        default: ;
      endcase
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] node,
                               logic last);
      graph_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d node %0d last %0d", status, node, last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (node !== want.node) begin
        $error("node: expected %0d, actual %0d", want.node, node);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

### tb/tb_adjacency_matrix_topological_sort_unit.sv
// Top-level testbench for the adjacency matrix topological sort unit: directed
// graph edits and sorts, then random graph-building sequences with random stalls.
// Depends on amts_pkg, amts_tb_pkg, the two channel interfaces and the unit itself.
module tb_adjacency_matrix_topological_sort_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import amts_pkg::*;
  import amts_tb_pkg::*;

  localparam int TOTAL_REQUESTS = 470;
  localparam int QUIET_TAIL     = 60;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = GRAPH_SLOTS * (GRAPH_SLOTS + 3) + 8;

  logic clk;
  logic rst;

  amts_cmd_if    req_ch();
  amts_result_if res_ch();

  toposort_scoreboard tracker = new();
  bit idling_on;
  int requests_issued;
  int quiet_cycles;

  adjacency_matrix_topological_sort_unit #(
    .MAX_NODES(GRAPH_SLOTS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (req_ch),
    .result (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] src,
                              input logic [SLOT_W-1:0] dst);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.op    = op;
    req_ch.src   = src;
    req_ch.dest  = dst;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(op, src, dst);
    if (op <= OP_SORT) requests_issued++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    req_ch.valid = 1'b0;
    while (tracker.expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [SLOT_W-1:0] pick_slot();
    int live[$];
    for (int i = 0; i < GRAPH_SLOTS; i++) begin
      if (tracker.node_valid[i]) live.push_back(i);
    end
    if (live.size() == 0) return SLOT_W'($urandom_range(0, 31));
    return SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  task automatic random_edit();
    int pairs[$];
    int pick;
    logic [SLOT_W-1:0] a;
    logic [SLOT_W-1:0] b;
    a = pick_slot();
    b = pick_slot();
    case ($urandom_range(0, 3))
      0: begin
        for (int d = 0; d < GRAPH_SLOTS; d++) begin
          for (int s = 0; s < GRAPH_SLOTS; s++) begin
            if (tracker.edge_rows[d][s]) pairs.push_back(s * GRAPH_SLOTS + d);
          end
        end
        if (pairs.size() != 0) begin
          pick = pairs[$urandom_range(0, pairs.size() - 1)];
          a = SLOT_W'(pick / GRAPH_SLOTS);
          b = SLOT_W'(pick % GRAPH_SLOTS);
        end
        send_request(OP_DEL_EDGE, a, b);
      end
      1: send_request(OP_DEL_NODE, a, b);
      2: send_request(OP_ADD_NODE, a, b);
      default: send_request(OP_ADD_EDGE, (a < b) ? a : b, (a < b) ? b : a);
    endcase
  endtask

  task automatic build_episode(input bit fill, input bit messy);
    int target;
    int edges;
    int pick;
    logic [SLOT_W-1:0] a;
    logic [SLOT_W-1:0] b;
    if ($urandom_range(0, 1)) begin
      for (int k = 0; k < GRAPH_SLOTS; k++) begin
        if (tracker.node_valid[k]) begin
          send_request(OP_DEL_NODE, SLOT_W'(k), SLOT_W'($urandom_range(0, 31)));
        end
      end
    end
    target = fill ? GRAPH_SLOTS : $urandom_range(1, 16);
    while (tracker.node_count < target) begin
      send_request(OP_ADD_NODE, SLOT_W'($urandom_range(0, 31)),
                   SLOT_W'($urandom_range(0, 31)));
    end
    if (fill) begin
      send_request(OP_ADD_NODE, SLOT_W'($urandom_range(0, 31)),
                   SLOT_W'($urandom_range(0, 31)));
    end
    edges = $urandom_range(0, (target < 20) ? 2 * target : 40);
    for (int k = 0; k < edges; k++) begin
      a = pick_slot();
      b = pick_slot();
      pick = messy ? $urandom_range(0, 99) : 0;
      if (pick < 80) begin
        if (a != b) send_request(OP_ADD_EDGE, (a < b) ? a : b, (a < b) ? b : a);
      end else if (pick < 94) begin
        send_request(OP_ADD_EDGE, a, b);
      end else if (pick < 97) begin
        send_request(OP_ADD_EDGE, a, a);
      end else begin
        send_request(OP_ADD_EDGE, SLOT_W'($urandom_range(0, 31)),
                     SLOT_W'($urandom_range(0, 31)));
      end
    end
    send_request(OP_SORT, SLOT_W'($urandom_range(0, 31)), SLOT_W'($urandom_range(0, 31)));
    repeat ($urandom_range(1, 4)) random_edit();
    send_request(OP_SORT, SLOT_W'($urandom_range(0, 31)), SLOT_W'($urandom_range(0, 31)));
  endtask

  task automatic noise_episode();
    logic [SLOT_W-1:0] a;
    logic [SLOT_W-1:0] b;
    repeat (12) begin
      a = $urandom_range(0, 1) ? pick_slot() : SLOT_W'($urandom_range(0, 31));
      b = $urandom_range(0, 1) ? pick_slot() : SLOT_W'($urandom_range(0, 31));
      send_request(OP_W'($urandom_range(0, 7)), a, b);
    end
  endtask

  task automatic directed_requests();
    send_request(OP_SORT, 5'd0, 5'd0);
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
      send_request(OP_W'(op), 5'd31, 5'd31);
    end
    send_request(OP_DEL_NODE, 5'd31, 5'd0);
    send_request(OP_ADD_EDGE, 5'd0, 5'd31);
    repeat (3) send_request(OP_ADD_NODE, 5'd31, 5'd31);
    send_request(OP_ADD_EDGE, 5'd0, 5'd1);
    send_request(OP_ADD_EDGE, 5'd0, 5'd1);
    send_request(OP_DEL_EDGE, 5'd1, 5'd2);
    send_request(OP_ADD_EDGE, 5'd1, 5'd2);
    send_request(OP_SORT, 5'd31, 5'd31);
    // A back edge closes a cycle through every node.
    send_request(OP_ADD_EDGE, 5'd2, 5'd0);
    send_request(OP_SORT, 5'd0, 5'd0);
    send_request(OP_DEL_EDGE, 5'd2, 5'd0);
    send_request(OP_ADD_EDGE, 5'd1, 5'd1);
    send_request(OP_SORT, 5'd0, 5'd0);
    send_request(OP_DEL_NODE, 5'd1, 5'd0);
    send_request(OP_DEL_NODE, 5'd1, 5'd0);
    send_request(OP_DEL_EDGE, 5'd31, 5'd31);
    send_request(OP_ADD_NODE, 5'd0, 5'd0);
    send_request(OP_SORT, 5'd0, 5'd0);
  endtask

  initial begin
    int episode;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op    = OP_ADD_NODE;
    req_ch.src   = '0;
    req_ch.dest  = '0;
    idling_on    = 1'b1;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    directed_requests();
    wait_for_results();

    episode = 0;
    while (requests_issued < TOTAL_REQUESTS) begin
      if (requests_issued >= TOTAL_REQUESTS - QUIET_TAIL) begin
        idling_on = 1'b0;
      end else begin
        idling_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 5) == 0) wait_for_results();
      if (episode == 0) begin
        build_episode(1'b1, 1'b0);
      end else if ($urandom_range(0, 9) < 3) begin
        noise_episode();
      end else begin
        build_episode($urandom_range(0, 5) == 0, $urandom_range(0, 9) < 3);
      end
      episode++;
    end

    idling_on = 1'b0;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
      $display("tb_adjacency_matrix_topological_sort_unit: done, clean");
    end else begin
      $display("tb_adjacency_matrix_topological_sort_unit: done, errors");
    end
    $finish;
  end

  initial begin
    int stall_left;
    res_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else begin
        res_ch.ready = 1'b1;
        if (idling_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      tracker.check_result(res_ch.status, res_ch.node, res_ch.last);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_adjacency_matrix_topological_sort_unit: done, errors");
        $finish;
      end
    end
  end

endmodule

### sim.f
rtl/core/amts_pkg.sv
rtl/core/amts_cmd_if.sv
rtl/core/amts_result_if.sv
rtl/core/amts_ctrl.sv
rtl/core/amts_datapath.sv
rtl/core/adjacency_matrix_topological_sort_unit.sv
tb/amts_tb_pkg.sv
tb/tb_adjacency_matrix_topological_sort_unit.sv
